// ===== design/bdq_pkg.sv =====
// shared types and constants for the bounded deque with key removal
`default_nettype none

package bdq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VALUE_W       = 32;
  localparam int COUNT_W       = 5;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_REMOVE     = 3'd4,
    ACT_READ_OUT   = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_POP,
    ST_SEARCH,
    ST_SHIFT,
    ST_STREAM,
    ST_EMIT
  } ctl_state_t;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_INC,
    IDX_LAST
  } idx_op_t;

  typedef enum logic [1:0] {
    WR_FRONT,
    WR_BACK,
    WR_SHIFT
  } wr_sel_t;

  typedef enum logic [1:0] {
    HEAD_HOLD,
    HEAD_DEC,
    HEAD_INC
  } head_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef struct packed {
    logic     cmd_load;
    idx_op_t  idx_op;
    logic     wr_en;
    wr_sel_t  wr_sel;
    head_op_t head_op;
    cnt_op_t  cnt_op;
    logic     stat_load;
    status_t  stat_val;
    logic     data_load;
    logic     data_clr;
    logic     out_load;
    logic     out_stream;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    empty;
    logic    full;
    logic    match;
    logic    idx_last;
    logic    idx_end;
    logic    out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/bdq_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/bdq_ctrl.sv =====
// command sequencer for the deque: decodes each command and steps the walks
`default_nettype none

module bdq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bdq_pkg::sts_t sts,
  output bdq_pkg::cmd_t      cmd
);

  bdq_pkg::ctl_state_t state;
  bdq_pkg::ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == bdq_pkg::ST_IDLE);
    unique case (state)
      bdq_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.cmd_load = 1'b1;
          state_next   = bdq_pkg::ST_DISPATCH;
        end
      end
      bdq_pkg::ST_DISPATCH: begin
        cmd.data_clr = 1'b1;
        unique case (sts.action) inside
          bdq_pkg::ACT_PUSH_FRONT, bdq_pkg::ACT_PUSH_BACK: begin
            cmd.stat_load = 1'b1;
            state_next    = bdq_pkg::ST_EMIT;
            if (sts.full) begin
              cmd.stat_val = bdq_pkg::STAT_FULL;
            end else begin
              cmd.stat_val = bdq_pkg::STAT_OK;
              cmd.wr_en    = 1'b1;
              cmd.cnt_op   = bdq_pkg::CNT_INC;
              if (sts.action == bdq_pkg::ACT_PUSH_FRONT) begin
                cmd.wr_sel  = bdq_pkg::WR_FRONT;
                cmd.head_op = bdq_pkg::HEAD_DEC;
              end else begin
                cmd.wr_sel = bdq_pkg::WR_BACK;
              end
            end
          end
          bdq_pkg::ACT_POP_FRONT, bdq_pkg::ACT_POP_BACK: begin
            if (sts.empty) begin
              cmd.stat_load = 1'b1;
              cmd.stat_val  = bdq_pkg::STAT_EMPTY;
              state_next    = bdq_pkg::ST_EMIT;
            end else begin
              cmd.idx_op = (sts.action == bdq_pkg::ACT_POP_FRONT) ?
                           bdq_pkg::IDX_ZERO : bdq_pkg::IDX_LAST;
              state_next = bdq_pkg::ST_POP;
            end
          end
          bdq_pkg::ACT_REMOVE, bdq_pkg::ACT_READ_OUT: begin
            if (sts.empty) begin
              cmd.stat_load = 1'b1;
              cmd.stat_val  = bdq_pkg::STAT_EMPTY;
              state_next    = bdq_pkg::ST_EMIT;
            end else begin
              cmd.idx_op = bdq_pkg::IDX_ZERO;
              state_next = (sts.action == bdq_pkg::ACT_REMOVE) ?
                           bdq_pkg::ST_SEARCH : bdq_pkg::ST_STREAM;
            end
          end
          default: begin
            // unused codes answer ok and change nothing
            cmd.stat_load = 1'b1;
            cmd.stat_val  = bdq_pkg::STAT_OK;
            state_next    = bdq_pkg::ST_EMIT;
          end
        endcase
      end
      bdq_pkg::ST_POP: begin
        cmd.data_load = 1'b1;
        cmd.cnt_op    = bdq_pkg::CNT_DEC;
        cmd.stat_load = 1'b1;
        cmd.stat_val  = bdq_pkg::STAT_OK;
        if (sts.action == bdq_pkg::ACT_POP_FRONT) begin
          cmd.head_op = bdq_pkg::HEAD_INC;
        end
        state_next = bdq_pkg::ST_EMIT;
      end
      bdq_pkg::ST_SEARCH: begin
        if (sts.match) begin
          cmd.data_load = 1'b1;
          cmd.idx_op    = bdq_pkg::IDX_INC;
          state_next    = bdq_pkg::ST_SHIFT;
        end else if (sts.idx_last) begin
          cmd.stat_load = 1'b1;
          cmd.stat_val  = bdq_pkg::STAT_NOT_FOUND;
          state_next    = bdq_pkg::ST_EMIT;
        end else begin
          cmd.idx_op = bdq_pkg::IDX_INC;
        end
      end
      bdq_pkg::ST_SHIFT: begin
        // each step moves one later element a place toward the front
        if (sts.idx_end) begin
          cmd.cnt_op    = bdq_pkg::CNT_DEC;
          cmd.stat_load = 1'b1;
          cmd.stat_val  = bdq_pkg::STAT_OK;
          state_next    = bdq_pkg::ST_EMIT;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = bdq_pkg::WR_SHIFT;
          cmd.idx_op = bdq_pkg::IDX_INC;
        end
      end
      bdq_pkg::ST_STREAM: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_stream = 1'b1;
          if (sts.idx_last) begin
            state_next = bdq_pkg::ST_IDLE;
          end else begin
            cmd.idx_op = bdq_pkg::IDX_INC;
          end
        end
      end
      bdq_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = bdq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bdq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/bdq_dpath.sv =====
// datapath: ring pointers, element ram, walk index and result register
`default_nettype none

module bdq_dpath #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bdq_pkg::cmd_t                 cmd,
  output bdq_pkg::sts_t                      sts,
  input  wire logic [2:0]                    action,
  input  wire logic [bdq_pkg::VALUE_W-1:0]   value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         status,
  output logic [bdq_pkg::VALUE_W-1:0]        data,
  output logic [bdq_pkg::COUNT_W-1:0]        count,
  output logic                               last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [2:0]                  act;
  logic [bdq_pkg::VALUE_W-1:0] key;
  logic [AW-1:0]               head;
  logic [AW-1:0]               head_next;
  logic [CW-1:0]               cnt;
  logic [CW-1:0]               cnt_next;
  logic [CW-1:0]               idx;
  logic [CW-1:0]               idx_next;
  logic [AW-1:0]               rd_addr;
  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               front_addr;
  logic [AW-1:0]               inc_addr;
  logic [bdq_pkg::VALUE_W-1:0] rdata;
  bdq_pkg::status_t            stat_hold;
  logic [bdq_pkg::VALUE_W-1:0] data_hold;
  logic                        out_free;

  // sums here stay below twice the depth, so one subtract wraps them
  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(DEPTH)) ? (s - SW'(DEPTH)) : s;
    return r[AW-1:0];
  endfunction

  always_comb begin
    unique case (cmd.idx_op)
      bdq_pkg::IDX_HOLD: idx_next = idx;
      bdq_pkg::IDX_ZERO: idx_next = '0;
      bdq_pkg::IDX_INC:  idx_next = idx + CW'(1);
      bdq_pkg::IDX_LAST: idx_next = cnt - CW'(1);
      default:           idx_next = idx;
    endcase
  end

  // read one slot ahead so rdata lines up with idx
  assign rd_addr    = wrap(SW'(head) + SW'(idx_next));
  assign front_addr = wrap(SW'(head) + SW'(DEPTH - 1));
  assign inc_addr   = wrap(SW'(head) + SW'(1));

  always_comb begin
    unique case (cmd.wr_sel)
      bdq_pkg::WR_FRONT: wr_addr = front_addr;
      bdq_pkg::WR_BACK:  wr_addr = wrap(SW'(head) + SW'(cnt));
      bdq_pkg::WR_SHIFT: wr_addr = wrap(SW'(head) + SW'(idx) - SW'(1));
      default:           wr_addr = front_addr;
    endcase
  end

  always_comb begin
    unique case (cmd.head_op)
      bdq_pkg::HEAD_HOLD: head_next = head;
      bdq_pkg::HEAD_DEC:  head_next = front_addr;
      bdq_pkg::HEAD_INC:  head_next = inc_addr;
      default:            head_next = head;
    endcase
  end

  always_comb begin
    unique case (cmd.cnt_op)
      bdq_pkg::CNT_HOLD: cnt_next = cnt;
      bdq_pkg::CNT_INC:  cnt_next = cnt + CW'(1);
      bdq_pkg::CNT_DEC:  cnt_next = cnt - CW'(1);
      default:           cnt_next = cnt;
    endcase
  end

  bdq_ram #(
    .WIDTH (bdq_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (wr_addr),
    .wdata ((cmd.wr_sel == bdq_pkg::WR_SHIFT) ? rdata : key),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      cnt  <= '0;
      idx  <= '0;
    end else begin
      head <= head_next;
      cnt  <= cnt_next;
      idx  <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmd_load) begin
      act <= action;
      key <= value;
    end
    if (cmd.stat_load) begin
      stat_hold <= cmd.stat_val;
    end
    if (cmd.data_load) begin
      data_hold <= rdata;
    end else if (cmd.data_clr) begin
      data_hold <= '0;
    end
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      count <= bdq_pkg::COUNT_W'(cnt);
      if (cmd.out_stream) begin
        status <= bdq_pkg::STAT_OK;
        data   <= rdata;
        last   <= sts.idx_last;
      end else begin
        status <= stat_hold;
        data   <= data_hold;
        last   <= 1'b1;
      end
    end
  end

  assign sts.action   = bdq_pkg::action_t'(act);
  assign sts.empty    = (cnt == '0);
  assign sts.full     = (cnt == CW'(DEPTH));
  assign sts.match    = (rdata == key);
  assign sts.idx_last = ((SW'(idx) + SW'(1)) == SW'(cnt));
  assign sts.idx_end  = (idx == cnt);
  assign sts.out_free = out_free;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("element count above depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    SW'(head) < SW'(DEPTH))
    else $error("head pointer out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.cnt_op == bdq_pkg::CNT_INC) |-> !sts.full)
    else $error("count raised while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.cnt_op == bdq_pkg::CNT_DEC) |-> !sts.empty)
    else $error("count lowered while empty");

endmodule

`default_nettype wire

// ===== design/bounded_deque_with_key_removal.sv =====
// Bounded deque of signed 32-bit values with push, pop, remove by key and read out.
// One command is taken on the input channel (action, value) when in_valid and
// in_ready are both high; in_ready is high only while the sequencer is idle, so
// commands run one at a time. Results leave on the output channel (status, data,
// count, last), one transfer per result, with last high on the final one.
// Push, pop and unused codes give one result: after the input transfer the sequencer
// dispatches the command, a pop then reads its element, and the result is loaded.
// Remove by key reads one stored element per cycle through the element ram's
// single read port while it searches, then moves each later element one place
// toward the front, one per cycle, so that search and shift together visit each
// element once.
// Read out streams one element per cycle from the ram while the receiver keeps
// out_ready high.
// The result register frees the sequencer: a new command is taken while the
// previous final result still waits for its transfer. While a result waits on a
// low out_ready, the result register and the stream or emit step both hold.
// Synchronous reset empties the store (head and count go to zero) and drops
// out_valid; the stored words themselves are not cleared.
`default_nettype none

module bounded_deque_with_key_removal #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [2:0]                          action,
  input  wire logic signed [bdq_pkg::VALUE_W-1:0]  value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [1:0]                               status,
  output logic signed [bdq_pkg::VALUE_W-1:0]       data,
  output logic [bdq_pkg::COUNT_W-1:0]              count,
  output logic                                     last
);

  bdq_pkg::cmd_t cmd;
  bdq_pkg::sts_t sts;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .action    (action),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .data      (data),
    .count     (count),
    .last      (last)
  );

endmodule

`default_nettype wire

// ===== tb/bounded_deque_with_key_removal_test.sv =====
// self-checking testbench for the bounded deque with key removal
module bounded_deque_with_key_removal_test;
  import bdq_pkg::*;

  localparam int STORE_DEPTH = DEPTH_DEFAULT;
  // codes outside the action set, the block treats them as no-ops
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  typedef struct {
    status_t                    status;
    logic signed [VALUE_W-1:0]  data;
    logic [COUNT_W-1:0]         count;
    logic                       last;
  } deque_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [2:0]                 action = ACT_PUSH_FRONT;
  logic signed [VALUE_W-1:0]  value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [1:0]                 status;
  logic signed [VALUE_W-1:0]  data;
  logic [COUNT_W-1:0]         count;
  logic                       last;

  // predicted contents of the deque, kept as a ring like the block's own
  logic signed [VALUE_W-1:0]  shadow_words [STORE_DEPTH];
  int                         shadow_head = 0;
  int                         shadow_held = 0;

  deque_result_t              pending_results [$];
  int                         mismatch_count = 0;
  int                         in_gap_max = 18;
  int                         out_gap_max = 18;

  bounded_deque_with_key_removal #(
    .DEPTH(STORE_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .data     (data),
    .count    (count),
    .last     (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s: got %h, want %h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  function automatic void push_expected(input status_t st,
                                        input logic signed [VALUE_W-1:0] word,
                                        input logic fin);
    deque_result_t r;
    r.status = st;
    r.data   = word;
    r.count  = shadow_held[COUNT_W-1:0];
    r.last   = fin;
    pending_results.push_back(r);
  endfunction

  function automatic void apply_command(input logic [2:0] act,
                                        input logic signed [VALUE_W-1:0] val);
    int pos;
    int i;
    logic signed [VALUE_W-1:0] word;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (shadow_held >= STORE_DEPTH) begin
          push_expected(STAT_FULL, '0, 1'b1);
        end else begin
          if (act == ACT_PUSH_FRONT) begin
            shadow_head = (shadow_head + STORE_DEPTH - 1) % STORE_DEPTH;
            shadow_words[shadow_head] = val;
          end else begin
            shadow_words[(shadow_head + shadow_held) % STORE_DEPTH] = val;
          end
          shadow_held++;
          push_expected(STAT_OK, '0, 1'b1);
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (shadow_held == 0) begin
          push_expected(STAT_EMPTY, '0, 1'b1);
        end else begin
          if (act == ACT_POP_FRONT) begin
            word = shadow_words[shadow_head];
            shadow_head = (shadow_head + 1) % STORE_DEPTH;
          end else begin
            word = shadow_words[(shadow_head + shadow_held - 1) % STORE_DEPTH];
          end
          shadow_held--;
          push_expected(STAT_OK, word, 1'b1);
        end
      end
      ACT_REMOVE: begin
        if (shadow_held == 0) begin
          push_expected(STAT_EMPTY, '0, 1'b1);
        end else begin
          pos = shadow_held;
          for (i = 0; i < shadow_held; i++) begin
            if (shadow_words[(shadow_head + i) % STORE_DEPTH] == val) begin
              pos = i;
              break;
            end
          end
          if (pos == shadow_held) begin
            push_expected(STAT_NOT_FOUND, '0, 1'b1);
          end else begin
            word = shadow_words[(shadow_head + pos) % STORE_DEPTH];
            // close the gap toward the front
            for (i = pos; i + 1 < shadow_held; i++)
              shadow_words[(shadow_head + i) % STORE_DEPTH] =
                shadow_words[(shadow_head + i + 1) % STORE_DEPTH];
            shadow_held--;
            push_expected(STAT_OK, word, 1'b1);
          end
        end
      end
      ACT_READ_OUT: begin
        if (shadow_held == 0) begin
          push_expected(STAT_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < shadow_held; i++)
            push_expected(STAT_OK, shadow_words[(shadow_head + i) % STORE_DEPTH],
                          i + 1 == shadow_held);
        end
      end
      default: begin
        push_expected(STAT_OK, '0, 1'b1);
      end
    endcase
  endfunction

  task automatic send_command(input logic [2:0] act,
                              input logic signed [VALUE_W-1:0] val);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    value    <= val;
    do @(posedge clk); while (!(in_valid && in_ready));
    apply_command(act, val);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall before each transfer
  initial begin
    int stall;
    forever begin
      stall = $urandom_range(0, out_gap_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin : check_results
    deque_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", data, '0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (data !== want.data) report_mismatch("data", data, want.data);
        if (count !== want.count) report_mismatch("count", count, want.count);
        if (last !== want.last) report_mismatch("last", last, want.last);
      end
    end
  end

  function automatic logic signed [VALUE_W-1:0] random_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 6) - 3;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0000_0000;
          default: return -1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // mostly keys that are held, so removal finds something
  function automatic logic signed [VALUE_W-1:0] random_key();
    if (shadow_held > 0 && $urandom_range(0, 9) < 6)
      return shadow_words[(shadow_head + $urandom_range(0, shadow_held - 1)) % STORE_DEPTH];
    return random_word();
  endfunction

  task automatic test_empty_store();
    send_command(ACT_POP_FRONT, 0);
    send_command(ACT_POP_BACK, -1);
    send_command(ACT_REMOVE, 0);
    send_command(ACT_READ_OUT, 0);
  endtask

  task automatic test_fill_and_overflow();
    logic signed [VALUE_W-1:0] fill_words [16];
    fill_words = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 5, 5, -3, 1,
                   32'sh5555_5555, 32'shaaaa_aaaa, 7, 5, 1, 32'sh8000_0001,
                   32'sh7fff_fffe, 42};
    // alternating ends, so the head wraps below zero
    for (int k = 0; k < STORE_DEPTH; k++)
      send_command(k % 2 ? ACT_PUSH_BACK : ACT_PUSH_FRONT, fill_words[k % 16]);
    send_command(ACT_PUSH_FRONT, 9);
    send_command(ACT_PUSH_BACK, 9);
    send_command(ACT_READ_OUT, 0);
  endtask

  task automatic test_remove_by_key();
    send_command(ACT_REMOVE, 32'sh1234_5678);
    send_command(ACT_REMOVE, 5);
    send_command(ACT_REMOVE, 32'sh7fff_fffe);
  endtask

  task automatic test_pops_and_spare_codes();
    send_command(ACT_POP_FRONT, 0);
    send_command(ACT_POP_BACK, 0);
    send_command(ACT_SPARE_LO, 32'sh0bad_cafe);
    send_command(ACT_SPARE_HI, -1);
  endtask

  task automatic test_random_traffic(input int items);
    int  r;
    bit  filling;
    filling = 1'b1;
    for (int k = 0; k < items; k++) begin
      // swing between filling to the top and draining to the bottom
      if (shadow_held >= STORE_DEPTH - 1 && $urandom_range(0, 3) == 0) filling = 1'b0;
      else if (shadow_held <= 1) filling = 1'b1;
      r = $urandom_range(0, 99);
      if (r < (filling ? 70 : 25)) begin
        send_command($urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, random_word());
      end else begin
        case ($urandom_range(0, 9))
          0, 1: send_command(ACT_POP_FRONT, random_word());
          2, 3: send_command(ACT_POP_BACK, random_word());
          4, 5, 6: send_command(ACT_REMOVE, random_key());
          7, 8: send_command(ACT_READ_OUT, random_word());
          default: begin
            if ($urandom_range(0, 2) == 0)
              send_command($urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO, random_word());
            else
              send_command(ACT_REMOVE, random_key());
          end
        endcase
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_store();
    test_fill_and_overflow();
    test_remove_by_key();
    test_pops_and_spare_codes();
    test_random_traffic(80);
    wait_for_results();
    // stretch with no idling on either side
    in_gap_max  = 0;
    out_gap_max = 0;
    test_random_traffic(50);
    in_gap_max = 18;
    test_random_traffic(50);
    in_gap_max  = 0;
    out_gap_max = 18;
    test_random_traffic(60);
    wait_for_results();
    repeat (2 * STORE_DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
design/bdq_pkg.sv
design/bdq_ram.sv
design/bdq_ctrl.sv
design/bdq_dpath.sv
design/bounded_deque_with_key_removal.sv
tb/bounded_deque_with_key_removal_test.sv
